>>> rtl/wrps_pkg.sv
// Package: shared types and constants for the weighted rectangle point sampler.
package wrps_pkg;

  localparam int MaxRects   = 64;
  localparam int CoordBits  = 16;
  localparam int IdxBits    = $clog2(MaxRects);
  localparam int CntBits    = $clog2(MaxRects + 1);
  localparam int SampleBits = 38;
  localparam int TotalBits  = 39;
  localparam int SpanBits   = CoordBits + 1;
  localparam int OriginBits = 2 * CoordBits;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_PICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVERTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_PK_RD,
    S_PK_CHK,
    S_BS_RD,
    S_BS_CMP,
    S_BASE_RD,
    S_BASE,
    S_DIV,
    S_POINT,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic add_rd;    // read last prefix
    logic add_wr;    // write new entry
    logic clear;
    logic pk_rd;     // read total
    logic bs_start;
    logic bs_rd;
    logic bs_cmp;
    logic base_rd;
    logic base_ld;
    logic div_step;
    logic point;
    logic set_status;
    status_t status;
  } wrps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic inverted;
    logic out_range;
    logic bs_done;
    logic div_done;
  } wrps_sts_t;

endpackage

>>> rtl/wrps_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module wrps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/wrps_ctrl.sv
// Controller state machine of the weighted rectangle point sampler.
module wrps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  wrps_pkg::opcode_t in_op,
  input  logic              out_busy,
  output logic              in_ready,
  output logic              out_load,
  output wrps_pkg::wrps_cmd_t cmd,
  input  wrps_pkg::wrps_sts_t sts
);
  import wrps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_ADD:  state_next = S_ADD_RD;
            OP_PICK: state_next = S_PK_RD;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_ADD_RD:  state_next = (sts.full || sts.inverted) ? S_OUT : S_ADD_WR;
      S_ADD_WR:  state_next = S_OUT;
      S_PK_RD:   state_next = S_PK_CHK;
      S_PK_CHK:  state_next = sts.out_range ? S_OUT : S_BS_RD;
      S_BS_RD:   state_next = sts.bs_done ? S_BASE_RD : S_BS_CMP;
      S_BS_CMP:  state_next = S_BS_RD;
      S_BASE_RD: state_next = S_BASE;
      S_BASE:    state_next = S_DIV;
      S_DIV:     state_next = sts.div_done ? S_POINT : S_DIV;
      S_POINT:   state_next = S_OUT;
      S_OUT:     state_next = out_busy ? S_OUT : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        cmd.set_status = in_fire;
        cmd.clear = in_fire && (in_op == OP_CLEAR);
      end
      S_ADD_RD: begin
        cmd.set_status = 1'b1;
        cmd.status = sts.full ? ST_FULL : (sts.inverted ? ST_INVERTED : ST_OK);
      end
      S_ADD_WR:  cmd.add_wr = 1'b1;
      S_PK_RD:   cmd.pk_rd = 1'b1;
      S_PK_CHK: begin
        cmd.bs_start = 1'b1;
        cmd.set_status = sts.out_range;
        cmd.status = ST_RANGE;
      end
      S_BS_RD:   cmd.bs_rd = 1'b1;
      S_BS_CMP:  cmd.bs_cmp = 1'b1;
      S_BASE_RD: cmd.base_rd = 1'b1;
      S_BASE:    cmd.base_ld = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_POINT:   cmd.point = 1'b1;
      S_OUT:     out_load = !out_busy;
      default: ;
    endcase
    cmd.add_rd = (state == S_IDLE) && in_fire && (in_op == OP_ADD);
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_div_from_base: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) != S_DIV) |-> $past(state) == S_BASE)
    else $error("division entered wrongly");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_busy) |=> state == S_OUT) else $error("out dropped");
`endif
endmodule

>>> rtl/wrps_dp.sv
// Datapath: rectangle tables, binary search, restoring divider, point build.
module wrps_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          in_op,
  input  logic [wrps_pkg::CoordBits-1:0]  in_xl,
  input  logic [wrps_pkg::CoordBits-1:0]  in_yl,
  input  logic [wrps_pkg::CoordBits-1:0]  in_xh,
  input  logic [wrps_pkg::CoordBits-1:0]  in_yh,
  input  logic [wrps_pkg::SampleBits-1:0] in_sample,
  input  wrps_pkg::wrps_cmd_t cmd,
  output wrps_pkg::wrps_sts_t sts,
  output logic [wrps_pkg::CoordBits-1:0] res_x,
  output logic [wrps_pkg::CoordBits-1:0] res_y,
  output logic [5:0]          res_rect,
  output logic [1:0]          res_status
);
  import wrps_pkg::*;

  localparam int DivSteps = TotalBits;
  localparam int DcBits = $clog2(DivSteps + 1);

  logic signed [CoordBits-1:0] xl, yl, xh, yh;
  logic [SampleBits-1:0] sample;
  logic [CntBits-1:0] count;
  logic [IdxBits-1:0] lo, hi, mid;
  logic [TotalBits-1:0] pt_rdata, base, off_q;
  logic [SpanBits-1:0] span_rdata;
  logic [OriginBits-1:0] org_rdata;
  logic [TotalBits-1:0] rem;
  logic [DcBits-1:0] dcnt;
  logic [SpanBits-1:0] w, h;
  logic [TotalBits-1:0] new_total;
  logic [IdxBits-1:0] raddr;
  logic pt_we;
  logic signed [CoordBits:0] dx, dy;
  logic add_rd_q;

  assign dx = {xh[CoordBits-1], xh} - {xl[CoordBits-1], xl};
  assign dy = {yh[CoordBits-1], yh} - {yl[CoordBits-1], yl};
  assign w = SpanBits'(dx) + SpanBits'(1);
  assign h = SpanBits'(dy) + SpanBits'(1);
  // one multiply: operand prefix read in ADD_RD cycle into base
  assign new_total = ((count == '0) ? '0 : base) + TotalBits'(w * h);
  assign mid = lo + IdxBits'((hi - lo) >> 1);

  // read address is combinational so the RAM output lines up with the next state
  always_comb begin
    raddr = lo;
    if (cmd.add_rd || cmd.pk_rd) raddr = IdxBits'(count - CntBits'(1));
    else if (cmd.bs_rd) raddr = mid;
    else if (cmd.base_rd) raddr = lo - IdxBits'(1);
  end
  assign pt_we = cmd.add_wr;

  wrps_ram #(.Width(TotalBits), .Depth(MaxRects)) u_pt (
    .clk, .we(pt_we), .waddr(count[IdxBits-1:0]), .wdata(new_total),
    .raddr, .rdata(pt_rdata));
  wrps_ram #(.Width(SpanBits), .Depth(MaxRects)) u_span (
    .clk, .we(pt_we), .waddr(count[IdxBits-1:0]), .wdata(w),
    .raddr, .rdata(span_rdata));
  wrps_ram #(.Width(OriginBits), .Depth(MaxRects)) u_org (
    .clk, .we(pt_we), .waddr(count[IdxBits-1:0]), .wdata({yl, xl}),
    .raddr, .rdata(org_rdata));

  assign sts.full = (count == CntBits'(MaxRects));
  assign sts.inverted = (dx < 0) || (dy < 0);
  assign sts.out_range = (count == '0) || ({1'b0, sample} >= pt_rdata);
  assign sts.bs_done = !(lo < hi);
  assign sts.div_done = (dcnt == DcBits'(DivSteps));

  // restoring division: off_q holds dividend shifting into quotient
  logic [TotalBits:0] rsh;
  assign rsh = {rem, off_q[TotalBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      if (cmd.add_wr) count <= count + CntBits'(1);
    end
    if (cmd.load) begin
      xl <= in_xl; yl <= in_yl; xh <= in_xh; yh <= in_yh;
      sample <= in_sample;
      res_x <= '0; res_y <= '0; res_rect <= '0;
    end
    if (cmd.set_status) res_status <= cmd.status;
    // prefix before the new entry comes out of the RAM in the cycle after add_rd
    add_rd_q <= cmd.add_rd;
    if (add_rd_q) base <= pt_rdata;
    if (cmd.bs_start) begin
      lo <= '0; hi <= IdxBits'(count - CntBits'(1));
    end
    if (cmd.bs_cmp) begin
      if (pt_rdata > {1'b0, sample}) hi <= mid;
      else lo <= mid + IdxBits'(1);
    end
    if (cmd.base_ld) base <= (lo == '0) ? '0 : pt_rdata;
    if (cmd.div_step && dcnt == '0) begin
      off_q <= {1'b0, sample} - base;
      rem <= '0;
      dcnt <= dcnt + DcBits'(1);
    end else if (cmd.div_step) begin
      if (rsh >= {{(TotalBits-SpanBits+1){1'b0}}, span_rdata}) begin
        rem <= TotalBits'(rsh - {{(TotalBits-SpanBits+1){1'b0}}, span_rdata});
        off_q <= {off_q[TotalBits-2:0], 1'b1};
      end else begin
        rem <= rsh[TotalBits-1:0];
        off_q <= {off_q[TotalBits-2:0], 1'b0};
      end
      dcnt <= dcnt + DcBits'(1);
    end
    if (cmd.base_ld) dcnt <= '0;
    if (cmd.point) begin
      res_x <= CoordBits'(org_rdata[CoordBits-1:0] + rem[CoordBits-1:0]);
      res_y <= CoordBits'(org_rdata[OriginBits-1:CoordBits] + off_q[CoordBits-1:0]);
      res_rect <= 6'(lo);
      res_status <= ST_OK;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(MaxRects)) else $error("count overflow");
  a_no_wr_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |-> !sts.full) else $error("write to full table");
  a_bs_order: assert property (@(posedge clk) disable iff (rst)
    cmd.bs_cmp |-> lo <= hi) else $error("search bounds crossed");
`endif
endmodule

>>> rtl/weighted_rect_point_sampler_unit.sv
// Top level of the weighted rectangle point sampler.
// Takes one word at a time on s_axis and returns exactly one result word on
// m_axis per input word; each word is worked through before the next one is
// taken. Clear and unknown opcodes go straight to the output, an add does a
// prefix read, then one multiply-add write (skipped when the table is full or
// the corners are inverted), a pick checks the total first and stops there
// when it is out of range or hits an empty table, and a good pick runs a
// binary search with one registered RAM read per step, then a 39-step
// restoring divider (after its setup step) that splits the offset by the
// rectangle width. A finished result waits in the datapath while the
// previous result word is still stalled on m_axis, and no new word is taken
// during that wait.
module weighted_rect_point_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], corner_x_low[17:2], corner_y_low[33:18], corner_x_high[49:34],
  // corner_y_high[65:50], sample[103:66]
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_x[15:0], point_y[31:16], chosen_rect[37:32], status[39:38]
  output logic [39:0] m_axis_tdata
);
  import wrps_pkg::*;

  wrps_cmd_t cmd;
  wrps_sts_t sts;
  logic in_fire, out_load;
  logic [CoordBits-1:0] rx, ry;
  logic [5:0] rr;
  logic [1:0] rs;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  wrps_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_op(opcode_t'(s_axis_tdata[1:0])),
    .out_busy(m_axis_tvalid && !m_axis_tready),
    .in_ready(s_axis_tready), .out_load, .cmd, .sts);

  wrps_dp u_dp (
    .clk, .rst, .in_op(s_axis_tdata[1:0]),
    .in_xl(s_axis_tdata[17:2]), .in_yl(s_axis_tdata[33:18]),
    .in_xh(s_axis_tdata[49:34]), .in_yh(s_axis_tdata[65:50]),
    .in_sample(s_axis_tdata[103:66]), .cmd, .sts,
    .res_x(rx), .res_y(ry), .res_rect(rr), .res_status(rs));

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (out_load) m_axis_tdata <= {rs, rr, ry, rx};
  end

`ifndef SYNTHESIS
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !s_axis_tready) else $error("load while ready");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready) else $error("back to back accept");
`endif
endmodule
